// ===== hw/rtl/g711_pcm_decode_mixer_assert.svh =====
// ----------------------------------------------------------------------------
// g711_pcm_decode_mixer_assert
// Assertion helpers for the G.711 decode mixer.
// All checks are clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef G711_PCM_DECODE_MIXER_ASSERT_SVH
`define G711_PCM_DECODE_MIXER_ASSERT_SVH

// Condition must hold at every edge.
`define GPDM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define GPDM_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define GPDM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/gpdm_pkg.sv =====
// ----------------------------------------------------------------------------
// gpdm_pkg
// Shared constants, types and G.711 expansion functions for the decode mixer.
// ----------------------------------------------------------------------------
package gpdm_pkg;

  localparam int BUFFER_SLOTS = 512;
  localparam int MAX_RATIO    = 8;

  localparam int ADDR_W = $clog2(BUFFER_SLOTS);
  localparam int POS_W  = $clog2(BUFFER_SLOTS + 1);
  localparam int REP_W  = (MAX_RATIO > 1) ? $clog2(MAX_RATIO + 1) : 1;

  localparam int SLOT_INDEX_W = 9;
  localparam int SLOT_VALUE_W = 12;
  localparam int SAMPLE_W     = 16;
  localparam int VOLUME_W     = 3;
  localparam int RATIO_W      = 4;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 4;

  localparam logic [SLOT_VALUE_W-1:0] SILENCE_LEVEL = SLOT_VALUE_W'(16'h8000 >> 4);
  localparam logic [SLOT_VALUE_W-1:0] MIX_MAX       = SLOT_VALUE_W'(4095);

  localparam logic [7:0]  ALAW_XOR  = 8'h55;
  localparam logic [15:0] ULAW_BIAS = 16'h0084;

  typedef enum logic [1:0] {
    OP_BEGIN_BUFFER  = 2'd0,
    OP_BEGIN_CONTEXT = 2'd1,
    OP_MIX           = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    FMT_LINEAR = 2'd0,
    FMT_ALAW   = 2'd1,
    FMT_ULAW   = 2'd2,
    FMT_TONE   = 2'd3
  } fmt_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WAV_VOLUME        = 2'd0,
    REG_BACKGROUND_VOLUME = 2'd1,
    REG_RESAMPLE_RATIO    = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_ISSUE = 1'b1
  } state_e;

  // Fields of a mix request that the decoder needs.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_code;
    logic [1:0]          sample_format;
    logic [1:0]          fade;
    logic                use_background;
  } mix_req_t;

  // Decoded per-request command: value added to each slot and slot count.
  typedef struct packed {
    logic signed [SLOT_VALUE_W-1:0] add;
    logic [REP_W-1:0]               reps;
  } mix_cmd_t;

  typedef struct packed {
    logic [SLOT_INDEX_W-1:0] slot_index;
    logic [SLOT_VALUE_W-1:0] slot_value;
    logic                    overflow;
    logic                    last;
  } result_t;

  function automatic logic signed [SAMPLE_W-1:0] alaw_to_linear(input logic [7:0] code);
    logic [7:0]  a;
    logic [15:0] mag;
    a = code ^ ALAW_XOR;
    if (a[6:4] != 3'd0) begin
      mag = 16'(6'({a[3:0], 1'b1}) + 6'd32) << (4'(a[6:4]) + 4'd2);
    end else begin
      mag = 16'({a[3:0], 1'b1}) << 3;
    end
    return a[7] ? signed'(mag) : -signed'(mag);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] ulaw_to_linear(input logic [7:0] code);
    logic [7:0]  u;
    logic [15:0] mag;
    u   = ~code;
    mag = (16'({u[3:0], 3'b000}) + ULAW_BIAS) << u[6:4];
    return u[7] ? signed'(ULAW_BIAS - mag) : signed'(mag - ULAW_BIAS);
  endfunction

endpackage

// ===== hw/rtl/gpdm_if.sv =====
// ----------------------------------------------------------------------------
// gpdm_if
// Valid/ready channels of the decode mixer: mix requests, slot results, config.
// ----------------------------------------------------------------------------
interface gpdm_req_if;
  import gpdm_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  logic [SAMPLE_W-1:0] sample_code;
  logic [1:0]          sample_format;
  logic [1:0]          fade;
  logic                use_background;

  modport source (output valid, operation, sample_code, sample_format, fade,
                  use_background, input ready);
  modport sink   (input valid, operation, sample_code, sample_format, fade,
                  use_background, output ready);
endinterface

interface gpdm_rsp_if;
  import gpdm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [SLOT_INDEX_W-1:0] slot_index;
  logic [SLOT_VALUE_W-1:0] slot_value;
  logic                    overflow;
  logic                    last;

  modport source (output valid, slot_index, slot_value, overflow, last, input ready);
  modport sink   (input valid, slot_index, slot_value, overflow, last, output ready);
endinterface

interface gpdm_cfg_if;
  import gpdm_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/gpdm_decode.sv =====
// ----------------------------------------------------------------------------
// gpdm_decode
// Expands one sample, applies volume/fade attenuation, registers the command.
// ----------------------------------------------------------------------------
module gpdm_decode (
  input  logic                                    clk,
  input  logic                                    load,
  input  gpdm_pkg::mix_req_t                      req,
  input  logic signed [gpdm_pkg::VOLUME_W-1:0]    wav_volume,
  input  logic signed [gpdm_pkg::VOLUME_W-1:0]    background_volume,
  input  logic [gpdm_pkg::RATIO_W-1:0]            resample_ratio,
  output gpdm_pkg::mix_cmd_t                      cmd
);
  import gpdm_pkg::*;

  logic signed [SAMPLE_W-1:0] sample;
  logic signed [VOLUME_W-1:0] vol;
  logic signed [4:0]          file_shift;
  logic [3:0]                 total_shift;
  logic [REP_W-1:0]           file_reps;
  logic signed [SAMPLE_W-1:0] shifted;
  mix_cmd_t                   cmd_next;

  always_comb begin
    case (req.sample_format)
      FMT_ALAW: sample = alaw_to_linear(req.sample_code[7:0]);
      FMT_ULAW: sample = ulaw_to_linear(req.sample_code[7:0]);
      default:  sample = signed'(req.sample_code);
    endcase
  end

  assign vol = req.use_background ? background_volume : wav_volume;

  // File sample: fade + 2 - volume, floored at zero. Both floor shifts fold
  // into one arithmetic shift by the sum.
  assign file_shift = signed'(5'({3'b000, req.fade})) + 5'sd2 - 5'(vol);

  always_comb begin
    if (req.sample_format == FMT_TONE) begin
      total_shift = 4'(req.fade) + 4'd4;
    end else if (file_shift < 0) begin
      total_shift = 4'd4;
    end else begin
      total_shift = 4'(file_shift) + 4'd4;
    end
  end

  always_comb begin
    if (resample_ratio == '0) begin
      file_reps = REP_W'(1);
    end else if (int'(resample_ratio) > MAX_RATIO) begin
      file_reps = REP_W'(MAX_RATIO);
    end else begin
      file_reps = REP_W'(resample_ratio);
    end
  end

  assign shifted       = sample >>> total_shift;
  assign cmd_next.add  = SLOT_VALUE_W'(shifted);
  assign cmd_next.reps = (req.sample_format == FMT_TONE) ? REP_W'(1) : file_reps;

  always_ff @(posedge clk) begin
    if (load) begin
      cmd <= cmd_next;
    end
  end

endmodule

// ===== hw/rtl/g711_pcm_decode_mixer.sv =====
// ----------------------------------------------------------------------------
// g711_pcm_decode_mixer
// Sample decoder (linear, A-law, mu-law, tone point) with 12-bit saturating mix.
// ----------------------------------------------------------------------------
// Usage:
//   req  - one request per input item. Begin-buffer rewinds and makes every
//          slot read as silence (2048); begin-context only rewinds; a mix
//          request adds a decoded sample into resample_ratio slots (0 as 1,
//          max 8; one for a tone point). Taken only while no mix request runs.
//   rsp  - one result per slot write attempt, in slot order; last marks the
//          final one of a request. Past the buffer end: index 0, value 0,
//          overflow set.
//   cfg  - register writes (0 wav_volume, 1 background_volume,
//          2 resample_ratio), always ready; write only while idle.
// Timing: a mix request's command is registered in decode, then the block
//   issues one buffer read-modify-write per cycle while the result queue
//   has room; the buffer memory's single read port sets that rate. Each
//   result passes the read-stage registers and the result queue. Begin
//   requests act as soon as they are taken.
// Reset: clears position, fill count, queue and registers; no memory sweep,
//   the fill count marks which slots hold data since the last begin-buffer.
// Stall: a two-entry result queue; slot issue pauses when it would overflow.
// ----------------------------------------------------------------------------
module g711_pcm_decode_mixer (
  input  logic clk,
  input  logic rst,
  gpdm_req_if.sink   req,
  gpdm_rsp_if.source rsp,
  gpdm_cfg_if.sink   cfg
);
  import gpdm_pkg::*;

  `include "g711_pcm_decode_mixer_assert.svh"

  // Config registers
  logic signed [VOLUME_W-1:0] wav_volume;
  logic signed [VOLUME_W-1:0] background_volume;
  logic [RATIO_W-1:0]         resample_ratio;

  // Control
  state_e           state;
  state_e           state_next;
  logic [POS_W-1:0] pos;     // write position, 0..BUFFER_SLOTS
  logic [POS_W-1:0] fill;    // slots written since begin-buffer
  logic [REP_W-1:0] rep_cnt; // slots issued for current request
  logic             req_take;
  logic             mix_load;
  logic             issue;
  logic             issue_last;
  logic             in_range;
  logic             credit_ok;

  mix_req_t mreq;
  mix_cmd_t cmd;

  // Buffer memory, one read port and one write port
  logic [SLOT_VALUE_W-1:0] mem [BUFFER_SLOTS];
  logic [SLOT_VALUE_W-1:0] rdata;

  // Read-stage registers (slot op in flight)
  logic              pend_valid;
  logic              pend_ovf;
  logic              pend_fresh;
  logic              pend_last;
  logic [ADDR_W-1:0] pend_addr;

  // Merge
  logic [SLOT_VALUE_W-1:0]        base;
  logic signed [SLOT_VALUE_W+1:0] sum;
  logic [SLOT_VALUE_W-1:0]        mixed;
  result_t                        res_new;

  // Result queue
  result_t    q [2];
  logic       q_wr;
  logic       q_rd;
  logic [1:0] q_count;
  logic [2:0] occ_next;
  logic       pop;

  // -------------------------------------------------------------------------
  // Configuration
  // -------------------------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wav_volume        <= '0;
      background_volume <= '0;
      resample_ratio    <= RATIO_W'(1);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_WAV_VOLUME:        wav_volume        <= signed'(cfg.data[VOLUME_W-1:0]);
        REG_BACKGROUND_VOLUME: background_volume <= signed'(cfg.data[VOLUME_W-1:0]);
        REG_RESAMPLE_RATIO:    resample_ratio    <= cfg.data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Decode
  // -------------------------------------------------------------------------
  assign mreq.sample_code    = req.sample_code;
  assign mreq.sample_format  = req.sample_format;
  assign mreq.fade           = req.fade;
  assign mreq.use_background = req.use_background;

  assign req_take = req.valid && req.ready;
  assign mix_load = req_take && (req.operation == OP_MIX);

  gpdm_decode u_decode (
    .clk               (clk),
    .load              (mix_load),
    .req               (mreq),
    .wav_volume        (wav_volume),
    .background_volume (background_volume),
    .resample_ratio    (resample_ratio),
    .cmd               (cmd)
  );

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------
  assign in_range   = pos < POS_W'(BUFFER_SLOTS);
  assign issue_last = (rep_cnt == cmd.reps - REP_W'(1));

  // Queue room after this edge, plus the slot about to be issued.
  assign occ_next  = 3'(q_count) + 3'(pend_valid) - 3'(pop);
  assign credit_ok = occ_next < 3'd2;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (mix_load) state_next = ST_ISSUE;
      ST_ISSUE: if (credit_ok && issue_last) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    issue     = 1'b0;
    case (state)
      ST_IDLE:  req.ready = 1'b1;
      ST_ISSUE: issue     = credit_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pos     <= '0;
      fill    <= '0;
      rep_cnt <= '0;
    end else begin
      state <= state_next;
      if (req_take) begin
        rep_cnt <= '0;
        case (req.operation)
          OP_BEGIN_BUFFER: begin
            pos  <= '0;
            fill <= '0;
          end
          OP_BEGIN_CONTEXT: pos <= '0;
          default: ;
        endcase
      end else if (issue) begin
        rep_cnt <= rep_cnt + REP_W'(1);
        if (in_range) begin
          pos <= pos + POS_W'(1);
          if (pos == fill) begin
            fill <= fill + POS_W'(1);
          end
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Buffer read, then merge and write back from the read-stage registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (issue && in_range) begin
      rdata <= mem[pos[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_ovf   <= !in_range;
      pend_fresh <= (pos == fill);   // slot not written since begin-buffer
      pend_last  <= issue_last;
      pend_addr  <= pos[ADDR_W-1:0];
    end
  end

  assign base = pend_fresh ? SILENCE_LEVEL : rdata;
  assign sum  = signed'((SLOT_VALUE_W + 2)'(base)) + (SLOT_VALUE_W + 2)'(cmd.add);

  always_comb begin
    if (sum < 0) begin
      mixed = '0;
    end else if (sum > signed'((SLOT_VALUE_W + 2)'(MIX_MAX))) begin
      mixed = MIX_MAX;
    end else begin
      mixed = sum[SLOT_VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (pend_valid && !pend_ovf) begin
      mem[pend_addr] <= mixed;
    end
  end

  assign res_new.slot_index = pend_ovf ? '0 : SLOT_INDEX_W'(pend_addr);
  assign res_new.slot_value = pend_ovf ? '0 : mixed;
  assign res_new.overflow   = pend_ovf;
  assign res_new.last       = pend_last;

  // -------------------------------------------------------------------------
  // Result queue
  // -------------------------------------------------------------------------
  assign pop        = rsp.valid && rsp.ready;
  assign rsp.valid  = q_count != 2'd0;
  assign rsp.slot_index = q[q_rd].slot_index;
  assign rsp.slot_value = q[q_rd].slot_value;
  assign rsp.overflow   = q[q_rd].overflow;
  assign rsp.last       = q[q_rd].last;

  always_ff @(posedge clk) begin
    if (pend_valid) begin
      q[q_wr] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr    <= 1'b0;
      q_rd    <= 1'b0;
      q_count <= '0;
    end else begin
      if (pend_valid) q_wr <= !q_wr;
      if (pop)        q_rd <= !q_rd;
      q_count <= occ_next[1:0];
    end
  end

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `GPDM_ASSERT_ALWAYS(a_pos_within_fill, pos <= fill, "write position ahead of fill count")
  `GPDM_ASSERT_ALWAYS(a_fill_bound, fill <= POS_W'(BUFFER_SLOTS), "fill count past buffer end")
  `GPDM_ASSERT_IMPLY(a_queue_room, pend_valid, (q_count < 2'd2) || pop, "result queue overrun")
  `GPDM_ASSERT_NEXT(a_mix_starts, mix_load, state == ST_ISSUE, "mix request not issuing")

endmodule
